FILE: src/assert_macros.svh
// Assertion macros used by the top module of the resonator filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: src/trp_pkg.sv
// Types and constants of the two-pole resonator filter.
package trp_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned CoefW    = 19;
  localparam int unsigned HistW    = 17;
  localparam int unsigned FracW    = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = CoefW;
  // Accumulator covers the sum of three products with headroom.
  localparam int unsigned AccW     = CoefW + HistW + 3;

  localparam logic signed [CoefW-1:0] CoefInputReset = CoefW'(65536);

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CoefW-1:0]   coef_t;
  typedef logic signed [HistW-1:0]   hist_t;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CfgNotchMode  = 2'd0,
    CfgCoefInput  = 2'd1,
    CfgCoefFbOne  = 2'd2,
    CfgCoefFbTwo  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic  notch_mode;
    coef_t coef_input;
    coef_t coef_feedback_one;
    coef_t coef_feedback_two;
  } cfg_t;

  typedef struct packed {
    sample_t sample;
    logic    saturated;
    hist_t   hist_next;
  } mac_res_t;

endpackage

FILE: src/trp_if.sv
// Stream interfaces for the input and result channels of the resonator filter.
interface trp_in_if;
  logic             valid;
  logic             ready;
  trp_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface trp_out_if;
  logic             valid;
  logic             ready;
  trp_pkg::sample_t sample_out;
  logic             saturated;

  modport source (output valid, output sample_out, output saturated, input ready);
  modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

FILE: src/trp_cfg_regs.sv
// Configuration register file of the resonator filter.
module trp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [trp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [trp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output trp_pkg::cfg_t                 cfg_o
);
  import trp_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Decode a write into the addressed register; notch mode keeps only bit 0.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgNotchMode: cfg_d.notch_mode        = cfg_wdata_i[0];
        CfgCoefInput: cfg_d.coef_input        = coef_t'(cfg_wdata_i[CoefW-1:0]);
        CfgCoefFbOne: cfg_d.coef_feedback_one = coef_t'(cfg_wdata_i[CoefW-1:0]);
        CfgCoefFbTwo: cfg_d.coef_feedback_two = coef_t'(cfg_wdata_i[CoefW-1:0]);
      endcase
    end
  end

  // Reset leaves unity input gain and no feedback.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.notch_mode        <= 1'b0;
      cfg_q.coef_input        <= CoefInputReset;
      cfg_q.coef_feedback_one <= '0;
      cfg_q.coef_feedback_two <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/trp_mac.sv
// Multiply-accumulate, rounding and saturation of one filter sample.
module trp_mac (
  input  trp_pkg::cfg_t     cfg_i,
  input  trp_pkg::sample_t  sample_i,
  input  trp_pkg::hist_t    hist_one_i,
  input  trp_pkg::hist_t    hist_two_i,
  output trp_pkg::mac_res_t res_o
);
  import trp_pkg::*;

  localparam int unsigned ProdXW = CoefW + SampleW;
  localparam int unsigned ProdHW = CoefW + HistW;
  localparam int unsigned YW     = AccW - FracW;

  logic signed [ProdXW-1:0] prod_x;
  logic signed [ProdHW-1:0] prod_one;
  logic signed [ProdHW-1:0] prod_two;
  logic signed [AccW-1:0]   acc;
  logic signed [AccW-1:0]   acc_rnd;
  logic signed [YW-1:0]     y_wide;
  logic                     overflow;
  sample_t                  y_sat;

  // Three products, summed exactly in Q.16.
  assign prod_x   = cfg_i.coef_input * sample_i;
  assign prod_one = cfg_i.coef_feedback_one * hist_one_i;
  assign prod_two = cfg_i.coef_feedback_two * hist_two_i;
  assign acc      = AccW'(prod_x) + AccW'(prod_one) - AccW'(prod_two);

  // Round half up, then drop the fraction.
  assign acc_rnd = acc + AccW'(1 << (FracW - 1));
  assign y_wide  = acc_rnd[AccW-1:FracW];

  // The value fits when all bits above the sample's sign bit match it.
  assign overflow = (y_wide[YW-1:SampleW-1] != {(YW-SampleW+1){1'b0}}) &&
                    (y_wide[YW-1:SampleW-1] != {(YW-SampleW+1){1'b1}});

  always_comb begin
    if (!overflow) begin
      y_sat = y_wide[SampleW-1:0];
    end else if (y_wide[YW-1]) begin
      y_sat = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SampleW-1){1'b1}}};
    end
  end

  // History takes the output, or in notch mode output minus input.
  assign res_o.sample    = y_sat;
  assign res_o.saturated = overflow;
  assign res_o.hist_next = cfg_i.notch_mode ?
                           hist_t'({y_sat[SampleW-1], y_sat} -
                                   {sample_i[SampleW-1], sample_i}) :
                           hist_t'({y_sat[SampleW-1], y_sat});

endmodule

FILE: src/two_pole_resonator_filter.sv
// Two-pole resonator filter: y = a*x + b*h1 - c*h2 with Q2.16 coefficients
// written over the configuration port, rounded half up and saturated to 16
// bits, with a flag on every clipped sample. The history holds past outputs,
// or in notch mode past output minus input. The block takes one sample per
// clock cycle while the result side does not stall; the input register
// feeds the three multipliers, the sum and the saturation, which close the
// history loop combinationally, and a sample moving on loads the result
// register and the history. Stalls on the result side hold both stages in
// place; the input is still taken while the input stage is free or moving on.
module two_pole_resonator_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [trp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [trp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  trp_in_if.sink                        in_i,
  trp_out_if.source                     out_o
);
  import trp_pkg::*;

  cfg_t     cfg;
  mac_res_t mac_res;

  logic     s1_valid_q;
  sample_t  s1_sample_q;
  logic     out_valid_q;
  sample_t  out_sample_q;
  logic     out_sat_q;
  hist_t    hist_one_q;
  hist_t    hist_two_q;

  logic     advance;
  logic     s1_move;
  logic     in_take;

  trp_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  trp_mac u_mac (
    .cfg_i      (cfg),
    .sample_i   (s1_sample_q),
    .hist_one_i (hist_one_q),
    .hist_two_i (hist_two_q),
    .res_o      (mac_res)
  );

  // Handshake: the result register frees up when empty or taken.
  assign advance    = !out_valid_q || out_o.ready;
  assign s1_move    = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  // Control and history state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hist_one_q  <= '0;
      hist_two_q  <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_move) begin
        hist_one_q <= mac_res.hist_next;
        hist_two_q <= hist_one_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_sample_q <= in_i.sample_in;
    end
    if (s1_move) begin
      out_sample_q <= mac_res.sample;
      out_sat_q    <= mac_res.saturated;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_sample_q;
  assign out_o.saturated  = out_sat_q;

  `include "assert_macros.svh"

  // A clipped result sits at one of the two rails.
  `ASSERT_IMPLY(a_sat_rail, clk_i, rst_ni, out_valid_q && out_sat_q,
                (out_sample_q == 16'sh7fff) || (out_sample_q == 16'sh8000))
  // The older history takes the newer one whenever a sample is processed.
  `ASSERT_NEXT(a_hist_shift, clk_i, rst_ni, s1_move, hist_two_q == $past(hist_one_q))
  // History stays put while no sample is processed.
  `ASSERT_NEXT(a_hist_hold, clk_i, rst_ni, !s1_move, $stable(hist_one_q) && $stable(hist_two_q))
  // An empty result register never blocks the input.
  `ASSERT_IMPLY(a_no_block, clk_i, rst_ni, !out_valid_q, in_i.ready)

endmodule
